// ===== src/psvm_pkg.sv =====
// shared types and constants of the polyphonic sine voice mixer
// no dependencies; every other file refers to it by scoped names
package psvm_pkg;

  // field widths of the stream items and the configuration register
  localparam int SR_W       = 18;
  localparam int ID_W       = 16;
  localparam int NOTE_W     = 7;
  localparam int DELAY_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int SAMPLE_W   = 20;
  localparam int USER_W     = 2;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  // voice state widths
  localparam int PHASE_W = 32;
  localparam int INCR_W  = 32;
  localparam int STOP_W  = 17;

  // note split and increment division
  localparam int OCT_W      = 4;
  localparam int SEMI_W     = 4;
  localparam int MAX_OCTAVE = 10;
  localparam int FREQ_W     = 30;
  localparam int FREQ_FRAC  = 16;
  localparam int DEN_W      = SR_W + MAX_OCTAVE;
  localparam int NUM_W      = FREQ_W + FREQ_FRAC + 1;

  // sample rate after reset
  localparam logic [SR_W-1:0] SR_RESET = 18'd48000;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // sine polynomial coefficients, q15
  localparam int SIN_A      = 51472;
  localparam int SIN_B      = 21024;
  localparam int SIN_C      = 2320;
  localparam int SINE_MAX   = 32767;
  localparam int ROUND_HALF = 16384;

  // output saturation limits
  localparam int SAMPLE_MAX = 524287;
  localparam int SAMPLE_MIN = -524288;

  // op codes on the input stream
  localparam logic [USER_W-1:0] OP_TICK     = 2'd0;
  localparam logic [USER_W-1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [USER_W-1:0] OP_NOTE_OFF = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_NOTE_ON,
    CMD_NOTE_OFF
  } cmd_kind_t;

  // classified command as it travels through the queue
  typedef struct packed {
    cmd_kind_t            kind;
    logic [ID_W-1:0]      note_id;
    logic [OCT_W-1:0]     octave;
    logic [SEMI_W-1:0]    semi;
    logic [DELAY_W-1:0]   delay;
    logic [GAIN_W-1:0]    gain;
  } cmd_t;

  // one voice record in the voice memory
  typedef struct packed {
    logic [ID_W-1:0]           note_id;
    logic [PHASE_W-1:0]        phase;
    logic [INCR_W-1:0]         incr;
    logic [DELAY_W-1:0]        start;
    logic signed [STOP_W-1:0]  stop;
  } voice_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_SCAN,
    BK_WALK,
    BK_DRAIN
  } back_state_t;

  // q14.16 frequencies of the top octave, notes 120 to 131
  function automatic logic [FREQ_W-1:0] top_freq(input logic [SEMI_W-1:0] semi);
    logic [FREQ_W-1:0] f;
    case (semi)
      4'd0:    f = 30'd548668578;
      4'd1:    f = 30'd581294109;
      4'd2:    f = 30'd615859655;
      4'd3:    f = 30'd652480576;
      4'd4:    f = 30'd691279090;
      4'd5:    f = 30'd732384684;
      4'd6:    f = 30'd775934544;
      4'd7:    f = 30'd822074013;
      4'd8:    f = 30'd870957077;
      4'd9:    f = 30'd922746880;
      4'd10:   f = 30'd977616265;
      4'd11:   f = 30'd1035748353;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ===== src/polyphonic_sine_voice_mixer_top.sv =====
// polyphonic sine voice mixer, top level; uses psvm_pkg, front, fifo and back.
// tick: the back reads every voice, then drains the sine pipeline; the sample is
// loaded into the output register once the pipeline is empty and the output is free.
// note on: waits for the 47-step increment divider; note off: reads every voice in turn.
// a queue of four commands lets inputs be taken while the back is busy.
// rst is synchronous: all voices free, sample rate 48000, queue and output empty.
module polyphonic_sine_voice_mixer_top #(
  parameter int VOICES          = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // note_id[15:0], note_number[22:16], delay_samples[38:23], gain[54:39], zero[55]
  input  logic [psvm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [psvm_pkg::USER_W-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // sample[19:0], zero[23:20]
  output logic [psvm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [psvm_pkg::SR_W-1:0]       cfg_wdata
);

  logic [psvm_pkg::SR_W-1:0] sample_rate;

  logic           fr_valid;
  logic           fr_ready;
  psvm_pkg::cmd_t fr_data;
  logic           q_valid;
  logic           q_pop;
  psvm_pkg::cmd_t q_data;

  // sample rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= psvm_pkg::SR_RESET;
    end else if (cfg_we) begin
      sample_rate <= cfg_wdata;
    end
  end

  psvm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (fr_valid),
    .cmd_ready     (fr_ready),
    .cmd_data      (fr_data)
  );

  psvm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_data  (q_data)
  );

  psvm_back #(
    .VOICES          (VOICES),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .sample_rate   (sample_rate),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== src/psvm_fifo.sv =====
// short command queue between the front and the back of the mixer
// depends on psvm_pkg for cmd_t and the queue depth
module psvm_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  psvm_pkg::cmd_t  in_data,
  output logic            out_valid,
  input  logic            out_pop,
  output psvm_pkg::cmd_t  out_data
);

  localparam int PTR_W = $clog2(psvm_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(psvm_pkg::QUEUE_DEPTH + 1);

  psvm_pkg::cmd_t   slots [psvm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign in_ready  = fill != CNT_W'(psvm_pkg::QUEUE_DEPTH);
  assign out_valid = fill != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;
  assign out_data  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(psvm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(psvm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

// ===== src/psvm_front.sv =====
// input stage: takes stream transfers, drops unused ops, splits note numbers
// depends on psvm_pkg for op codes and cmd_t
module psvm_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // note_id[15:0], note_number[22:16], delay_samples[38:23], gain[54:39], zero[55]
  input  logic [psvm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [psvm_pkg::USER_W-1:0]     s_axis_tuser,
  output logic                            cmd_valid,
  input  logic                            cmd_ready,
  output psvm_pkg::cmd_t                  cmd_data
);

  localparam int ID_LSB    = 0;
  localparam int NOTE_LSB  = ID_LSB + psvm_pkg::ID_W;
  localparam int DELAY_LSB = NOTE_LSB + psvm_pkg::NOTE_W;
  localparam int GAIN_LSB  = DELAY_LSB + psvm_pkg::DELAY_W;

  // note / 12 as (note * 43) >> 9, exact over the 7-bit range after one fixup
  localparam int RECIP_12    = 43;
  localparam int RECIP_SHIFT = 9;
  localparam int PROD_W      = psvm_pkg::NOTE_W + 6;

  logic                          vld;
  psvm_pkg::cmd_t                cmd;
  psvm_pkg::cmd_t                cmd_next;
  logic                          accept;
  logic                          keep;
  logic [psvm_pkg::NOTE_W-1:0]   note;
  logic [PROD_W-1:0]             prod;
  logic [psvm_pkg::OCT_W-1:0]    oct_est;
  logic [psvm_pkg::NOTE_W-1:0]   rem_est;

  assign s_axis_tready = !vld || cmd_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd_valid     = vld;
  assign cmd_data      = cmd;

  // classify the op and split the note into octave and semitone
  always_comb begin
    note     = s_axis_tdata[NOTE_LSB +: psvm_pkg::NOTE_W];
    prod     = PROD_W'(note) * PROD_W'(RECIP_12);
    oct_est  = prod[RECIP_SHIFT +: psvm_pkg::OCT_W];
    rem_est  = note - psvm_pkg::NOTE_W'(oct_est) * psvm_pkg::NOTE_W'(12);
    keep     = 1'b1;
    cmd_next = '0;
    cmd_next.note_id = s_axis_tdata[ID_LSB +: psvm_pkg::ID_W];
    cmd_next.delay   = s_axis_tdata[DELAY_LSB +: psvm_pkg::DELAY_W];
    cmd_next.gain    = s_axis_tdata[GAIN_LSB +: psvm_pkg::GAIN_W];
    if (rem_est >= psvm_pkg::NOTE_W'(12)) begin
      cmd_next.octave = oct_est + 1'b1;
      cmd_next.semi   = psvm_pkg::SEMI_W'(rem_est - psvm_pkg::NOTE_W'(12));
    end else begin
      cmd_next.octave = oct_est;
      cmd_next.semi   = psvm_pkg::SEMI_W'(rem_est);
    end
    case (s_axis_tuser)
      psvm_pkg::OP_TICK:     cmd_next.kind = psvm_pkg::CMD_TICK;
      psvm_pkg::OP_NOTE_ON:  cmd_next.kind = psvm_pkg::CMD_NOTE_ON;
      psvm_pkg::OP_NOTE_OFF: cmd_next.kind = psvm_pkg::CMD_NOTE_OFF;
      default: begin
        cmd_next.kind = psvm_pkg::CMD_TICK;
        keep          = 1'b0;
      end
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      if (vld && cmd_ready) begin
        vld <= 1'b0;
      end
      if (accept && keep) begin
        vld <= 1'b1;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== src/psvm_div.sv =====
// restoring divider, one quotient bit per cycle, for the phase increment
// depends on psvm_pkg for operand widths
module psvm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [psvm_pkg::NUM_W-1:0]    num,
  input  logic [psvm_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [psvm_pkg::INCR_W-1:0]   quo
);

  localparam int STEP_W = $clog2(psvm_pkg::NUM_W);

  logic                          busy;
  logic [STEP_W-1:0]             step;
  logic [psvm_pkg::NUM_W-1:0]    num_sh;
  logic [psvm_pkg::DEN_W-1:0]    den_q;
  logic                          den_zero;
  logic [psvm_pkg::DEN_W-1:0]    rem;
  logic [psvm_pkg::INCR_W-1:0]   quo_acc;
  logic [psvm_pkg::DEN_W:0]      rem_sh;
  logic [psvm_pkg::DEN_W:0]      rem_sub;
  logic                          ge;

  // one trial subtraction
  always_comb begin
    rem_sh  = {rem, num_sh[psvm_pkg::NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
  end

  // only the low 32 quotient bits are kept; zero divisor gives zero
  assign quo = den_zero ? '0 : quo_acc;

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(psvm_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_sh   <= num;
      den_q    <= den;
      den_zero <= den == '0;
      rem      <= '0;
      quo_acc  <= '0;
    end else if (busy) begin
      num_sh  <= num_sh << 1;
      rem     <= ge ? rem_sub[psvm_pkg::DEN_W-1:0] : rem_sh[psvm_pkg::DEN_W-1:0];
      quo_acc <= {quo_acc[psvm_pkg::INCR_W-2:0], ge};
    end
  end

endmodule

// ===== src/psvm_back.sv =====
// voice engine: voice memory, note on/off handling, per-tick walk and mix
// depends on psvm_pkg and psvm_div
module psvm_back #(
  parameter int VOICES          = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  psvm_pkg::cmd_t                  q_data,
  output logic                            q_pop,
  input  logic [psvm_pkg::SR_W-1:0]       sample_rate,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // sample[19:0], zero[23:20]
  output logic [psvm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int IDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W   = $clog2(VOICES + 1);
  localparam int SUM_W   = 20 + $clog2(VOICES + 1);
  localparam int POS_W   = SINE_TABLE_BITS - 2;
  localparam int POS_PAD = 17 - SINE_TABLE_BITS;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(psvm_pkg::SAMPLE_MAX);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(psvm_pkg::SAMPLE_MIN);

  psvm_pkg::back_state_t state;
  psvm_pkg::back_state_t state_next;
  psvm_pkg::cmd_t        cur;

  logic [CNT_W-1:0]  cnt;
  logic              walk_done;
  logic [VOICES-1:0] active;
  logic              found;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  free_slot;

  // voice memory ports
  psvm_pkg::voice_t  mem [VOICES];
  psvm_pkg::voice_t  rd_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  psvm_pkg::voice_t  wr_data;

  // divider
  logic                          div_start;
  logic                          div_done;
  logic [psvm_pkg::INCR_W-1:0]   div_quo;
  logic [psvm_pkg::DEN_W-1:0]    div_den;
  logic [psvm_pkg::NUM_W-1:0]    div_num;

  // read stage decode
  logic                              hit;
  logic                              tick_hit;
  logic                              start_busy;
  logic                              stop_pos;
  logic signed [psvm_pkg::STOP_W-1:0] stop_n;
  logic                              voice_free;
  logic                              sounding;
  logic                              off_hit;
  logic [POS_W-1:0]                  pos;
  logic [15:0]                       x_raw;
  logic [15:0]                       x_val;

  // sine and mix pipeline
  logic        s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld;
  logic        s1_neg, s2_neg, s3_neg, s4_neg, s5_neg, s6_neg;
  logic [15:0] s1_x, s2_x, s2_x2, s3_x2, s3_x3, s4_x5;
  logic [31:0] s2_ax, s3_ax, s4_ax, s4_bx;
  logic [14:0] s5_s;
  logic [30:0] s6_mag;
  logic [31:0] sq_x, cube_x, fifth_x;
  logic [32:0] poly;
  logic [17:0] poly_q15;
  logic [31:0] term_rnd;
  logic [16:0] term;
  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] term_s;
  logic                    pipe_empty;

  // output register
  logic                              out_free;
  logic                              out_load;
  logic [psvm_pkg::SAMPLE_W-1:0]     sample;
  logic [psvm_pkg::SAMPLE_W-1:0]     sample_next;

  assign walk_done  = cnt == CNT_W'(VOICES);
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign pipe_empty = !rd_vld && !s1_vld && !s2_vld && !s3_vld && !s4_vld && !s5_vld && !s6_vld;
  assign m_axis_tdata = {{(psvm_pkg::OUT_DATA_W - psvm_pkg::SAMPLE_W){1'b0}}, sample};

  // lowest free voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // divider operands: round(f * 2^16 / (rate * 2^(10 - octave)))
  always_comb begin
    div_den = psvm_pkg::DEN_W'(sample_rate) <<
              (psvm_pkg::OCT_W'(psvm_pkg::MAX_OCTAVE) - q_data.octave);
    div_num = psvm_pkg::NUM_W'({psvm_pkg::top_freq(q_data.semi),
                                {psvm_pkg::FREQ_FRAC{1'b0}}}) +
              psvm_pkg::NUM_W'(div_den >> 1);
  end

  psvm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      psvm_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_data.kind)
            psvm_pkg::CMD_TICK:     state_next = psvm_pkg::BK_WALK;
            psvm_pkg::CMD_NOTE_ON:  state_next = free_found ? psvm_pkg::BK_DIVIDE
                                                            : psvm_pkg::BK_IDLE;
            psvm_pkg::CMD_NOTE_OFF: state_next = psvm_pkg::BK_SCAN;
            default:                state_next = psvm_pkg::BK_IDLE;
          endcase
        end
      end
      psvm_pkg::BK_DIVIDE: begin
        if (div_done) state_next = psvm_pkg::BK_IDLE;
      end
      psvm_pkg::BK_SCAN: begin
        if (walk_done && !rd_vld) state_next = psvm_pkg::BK_IDLE;
      end
      psvm_pkg::BK_WALK: begin
        if (walk_done) state_next = psvm_pkg::BK_DRAIN;
      end
      psvm_pkg::BK_DRAIN: begin
        if (pipe_empty && out_free) state_next = psvm_pkg::BK_IDLE;
      end
      default: state_next = psvm_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    rd_addr   = cnt[IDX_W-1:0];
    case (state)
      psvm_pkg::BK_IDLE: begin
        q_pop     = q_valid;
        div_start = q_valid && (q_data.kind == psvm_pkg::CMD_NOTE_ON) && free_found;
      end
      psvm_pkg::BK_SCAN,
      psvm_pkg::BK_WALK: begin
        rd_en = !walk_done;
      end
      psvm_pkg::BK_DRAIN: begin
        out_load = pipe_empty && out_free;
      end
      default: ;
    endcase
  end

  // read stage: tick update of one voice, or note off match
  always_comb begin
    hit        = rd_vld && active[rd_idx];
    tick_hit   = hit && (cur.kind == psvm_pkg::CMD_TICK);
    start_busy = rd_data.start != '0;
    stop_pos   = !rd_data.stop[psvm_pkg::STOP_W-1] && (rd_data.stop != '0);
    stop_n     = stop_pos ? rd_data.stop - psvm_pkg::STOP_W'(1) : rd_data.stop;
    voice_free = tick_hit && !start_busy && (stop_n == '0);
    sounding   = tick_hit && !start_busy && (stop_n != '0);
    off_hit    = hit && (cur.kind == psvm_pkg::CMD_NOTE_OFF) && !found &&
                 (rd_data.note_id == cur.note_id);
    pos        = rd_data.phase[psvm_pkg::PHASE_W-3 -: POS_W];
    x_raw      = {1'b0, pos, {POS_PAD{1'b0}}};
    x_val      = rd_data.phase[psvm_pkg::PHASE_W-2] ? 16'd32768 - x_raw : x_raw;
  end

  // voice memory write selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = rd_data;
    if (state == psvm_pkg::BK_DIVIDE && div_done) begin
      wr_en           = 1'b1;
      wr_addr         = free_slot;
      wr_data.note_id = cur.note_id;
      wr_data.phase   = '0;
      wr_data.incr    = div_quo;
      wr_data.start   = cur.delay;
      wr_data.stop    = '1;
    end else if (tick_hit && start_busy) begin
      wr_en         = 1'b1;
      wr_data.start = rd_data.start - 1'b1;
    end else if (sounding) begin
      wr_en         = 1'b1;
      wr_data.phase = rd_data.phase + rd_data.incr;
      wr_data.stop  = stop_n;
    end else if (off_hit) begin
      wr_en        = 1'b1;
      wr_data.stop = {1'b0, cur.delay};
    end
  end

  // voice memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= psvm_pkg::BK_IDLE;
      cnt    <= '0;
      rd_vld <= 1'b0;
      active <= '0;
      found  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (q_pop) begin
        cnt <= '0;
      end else if (rd_en) begin
        cnt <= cnt + 1'b1;
      end
      if (state == psvm_pkg::BK_DIVIDE && div_done) begin
        active[free_slot] <= 1'b1;
      end
      if (voice_free) begin
        active[rd_idx] <= 1'b0;
      end
      if (q_pop) begin
        found <= 1'b0;
      end else if (off_hit) begin
        found <= 1'b1;
      end
    end
  end

  // command and address registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur       <= q_data;
      free_slot <= free_idx;
    end
    rd_idx <= rd_addr;
  end

  // pipeline arithmetic
  always_comb begin
    sq_x     = {16'b0, s1_x} * {16'b0, s1_x};
    cube_x   = {16'b0, s2_x2} * {16'b0, s2_x};
    fifth_x  = {16'b0, s3_x3} * {16'b0, s3_x2};
    poly     = 33'(s4_ax) + 33'(32'(psvm_pkg::SIN_C) * {16'b0, s4_x5}) - 33'(s4_bx);
    poly_q15 = poly[32:15];
    term_rnd = 32'(s6_mag) + 32'(psvm_pkg::ROUND_HALF);
    term     = term_rnd[31:15];
    term_s   = s6_neg ? -$signed(SUM_W'(term)) : $signed(SUM_W'(term));
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
    end else begin
      s1_vld <= sounding;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
    end
  end

  // pipeline payload: x, x^2, x^3, x^5, polynomial, gain, accumulate
  always_ff @(posedge clk) begin
    s1_neg <= rd_data.phase[psvm_pkg::PHASE_W-1];
    s1_x   <= x_val;

    s2_neg <= s1_neg;
    s2_x   <= s1_x;
    s2_x2  <= sq_x[30:15];
    s2_ax  <= 32'(psvm_pkg::SIN_A) * {16'b0, s1_x};

    s3_neg <= s2_neg;
    s3_x2  <= s2_x2;
    s3_x3  <= cube_x[30:15];
    s3_ax  <= s2_ax;

    s4_neg <= s3_neg;
    s4_x5  <= fifth_x[30:15];
    s4_ax  <= s3_ax;
    s4_bx  <= 32'(psvm_pkg::SIN_B) * {16'b0, s3_x3};

    s5_neg <= s4_neg;
    s5_s   <= (poly_q15 > 18'(psvm_pkg::SINE_MAX)) ? 15'(psvm_pkg::SINE_MAX)
                                                   : poly_q15[14:0];

    s6_neg <= s5_neg;
    s6_mag <= {16'b0, s5_s} * {15'b0, cur.gain};

    if (q_pop) begin
      acc <= '0;
    end else if (s6_vld) begin
      acc <= acc + term_s;
    end
  end

  // saturate the mix
  always_comb begin
    if (acc > SAT_MAX) begin
      sample_next = psvm_pkg::SAMPLE_W'(SAT_MAX);
    end else if (acc < SAT_MIN) begin
      sample_next = psvm_pkg::SAMPLE_W'(SAT_MIN);
    end else begin
      sample_next = acc[psvm_pkg::SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample <= sample_next;
    end
  end

endmodule
